// ===== design/assert_macros.svh =====
// Assertion macros for the top level of the substring search core.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sss assertion failed");

`endif

// ===== design/sss_pkg.sv =====
// Package for the stream substring search core: sizes, register indexes,
// request/result structs and internal types. No dependencies.
package sss_pkg;

  localparam int MAX_PAT    = 32;
  localparam int LANES      = 8;
  localparam int POS_BITS   = 32;
  localparam int OUT_W      = 32;
  localparam int LEN_W      = 6;
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = PAT_WORDS * 8;
  localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
  localparam int HIST_DEPTH = MAX_PAT - 1;
  localparam int CAT_DEPTH  = HIST_DEPTH + LANES;
  localparam int CAT_IDX_W  = $clog2(CAT_DEPTH);
  localparam int CNT_W      = $clog2(LANES + 1);
  localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int WIDE_W     = ((POS_BITS > OUT_W) ? POS_BITS : OUT_W) + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd4;

  typedef logic [MAX_PAT-1:0][7:0] win_t;
  typedef logic [MAX_PAT-1:0]      mask_t;
  typedef logic [LANES-1:0]        lane_hits_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_of_stream;
    logic        last_of_stream;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] match_position;
  } out_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] position;
  } match_t;

endpackage

// ===== design/sss_lane.sv =====
// One compare lane: checks whether the pattern ends at this lane's byte.
// Depends on sss_pkg for the window and mask types.
module sss_lane import sss_pkg::*; (
  input  win_t  win,
  input  win_t  tail_pat,
  input  mask_t tail_mask,
  output logic  hit
);

  mask_t byte_ok;

  always_comb begin
    for (int k = 0; k < MAX_PAT; k++) begin
      byte_ok[k] = (win[k] == tail_pat[k]) | ~tail_mask[k];
    end
  end

  assign hit = &byte_ok;

endmodule

// ===== design/sss_merge.sv =====
// Merges the lane hits: picks the earliest qualified lane and forms the
// saturated start offset. Depends on sss_pkg.
module sss_merge import sss_pkg::*; (
  input  lane_hits_t          lane_hits,
  input  logic [CNT_W-1:0]    cnt,
  input  logic [POS_BITS-1:0] bytes_seen,
  input  logic [LEN_W-1:0]    pat_len,
  input  logic                can_match,
  output match_t              match
);

  localparam logic [POS_BITS:0] PosMax = {1'b0, {POS_BITS{1'b1}}};
  localparam logic [WIDE_W-1:0] OutMax = WIDE_W'({OUT_W{1'b1}});

  lane_hits_t          qual;
  logic [LANE_W-1:0]   sel;
  logic [POS_BITS:0]   seen_end;
  logic [WIDE_W-1:0]   pos_full;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qual[i] = lane_hits[i] && can_match && (CNT_W'(i) < cnt) &&
                (({1'b0, bytes_seen} + (POS_BITS+1)'(i + 1)) >= (POS_BITS+1)'(pat_len));
    end
    // earliest lane wins
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (qual[i]) begin
        sel = LANE_W'(i);
      end
    end
    seen_end = {1'b0, bytes_seen} + (POS_BITS+1)'(sel) + (POS_BITS+1)'(1);
    if (seen_end >= PosMax) begin
      pos_full = WIDE_W'(PosMax);
    end else begin
      pos_full = WIDE_W'(seen_end - (POS_BITS+1)'(pat_len));
    end
    match.hit = |qual;
    if (pos_full > OutMax) begin
      match.position = '1;
    end else begin
      match.position = pos_full[OUT_W-1:0];
    end
  end

endmodule

// ===== design/stream_substring_search_core.sv =====
// Top level of the stream substring search core: config registers, history,
// lane array, merge and output register. Depends on sss_pkg, sss_lane,
// sss_merge and assert_macros.svh.
//
// Finds the first exact occurrence of a pattern of 1 to 32 bytes in a byte
// stream delivered up to eight bytes per request. One request is accepted
// every clock cycle while in_stall is low; the result of a request shows on
// out_valid in the cycle after it. The limit is the loop through the
// 31-byte history, the position counter and the done flag, which every
// request updates before the next one can be examined. Eight compare lanes
// test every byte position of a request against the history-extended window
// in parallel, and the merge stage takes the earliest lane that matched. At
// most one result per stream: found with the start offset on the first
// match, or found clear at the last request when nothing matched. The input
// stalls only while a result waits in the output register and the result
// side stalls. Configuration registers are written through cfg_* and must
// only change while no stream is in flight; cfg_ready is always high.
module stream_substring_search_core import sss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam logic [POS_BITS:0] PosMax = {1'b0, {POS_BITS{1'b1}}};

  // configuration
  logic [LEN_W-1:0]            pat_len_r;
  logic [PAT_WORDS-1:0][63:0]  pat_word_r;
  // stream state
  logic [HIST_DEPTH-1:0][7:0]  hist_r, hist_nxt;
  logic [POS_BITS-1:0]         bytes_seen_r, bytes_seen_nxt;
  logic                        search_done_r, search_done_nxt;
  // output register
  logic                        out_valid_r, out_valid_nxt;
  out_rsp_t                    out_rsp_r, out_rsp_nxt;

  logic                        in_fire, cfg_write;
  logic [HIST_DEPTH-1:0][7:0]  hist_eff;
  logic [POS_BITS-1:0]         seen_eff;
  logic                        done_eff;
  logic [CNT_W-1:0]            cnt;
  logic [CAT_DEPTH-1:0][7:0]   cat;
  logic [PAT_BYTES-1:0][7:0]   pat_bytes;
  win_t                        tail_pat;
  mask_t                       tail_mask;
  logic                        can_match;
  win_t [LANES-1:0]            lane_win;
  lane_hits_t                  lane_hits;
  match_t                      match;
  logic [HIST_DEPTH-1:0][7:0]  hist_push;
  logic [POS_BITS:0]           seen_sum;
  logic [POS_BITS-1:0]         seen_sat;
  logic                        res_load;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Start of stream: clear history, position and done flag ahead of the search.
  assign hist_eff = in_req.first_of_stream ? '0 : hist_r;
  assign seen_eff = in_req.first_of_stream ? '0 : bytes_seen_r;
  assign done_eff = in_req.first_of_stream ? 1'b0 : search_done_r;

  // Clamp the byte count to the lane count.
  assign cnt = (in_req.byte_count > 4'(LANES)) ? CNT_W'(LANES) : CNT_W'(in_req.byte_count);

  // Age-ordered byte line: history oldest at index 0, then this request's bytes.
  always_comb begin
    for (int h = 0; h < HIST_DEPTH; h++) begin
      cat[HIST_DEPTH-1-h] = hist_eff[h];
    end
    for (int i = 0; i < LANES; i++) begin
      cat[HIST_DEPTH+i] = in_req.data_word[8*i +: 8];
    end
  end

  // Pattern right-aligned to its last byte: entry k is the byte k places
  // before the pattern end, masked off past the pattern length.
  assign pat_bytes = pat_word_r;
  assign can_match = (pat_len_r != '0) && (pat_len_r <= LEN_W'(MAX_PAT));

  always_comb begin
    logic [LEN_W-1:0] tail_idx;
    for (int k = 0; k < MAX_PAT; k++) begin
      tail_idx     = pat_len_r - LEN_W'(1) - LEN_W'(k);
      tail_mask[k] = LEN_W'(k) < pat_len_r;
      tail_pat[k]  = tail_mask[k] ? pat_bytes[tail_idx[PAT_IDX_W-1:0]] : 8'h00;
    end
  end

  // Lane i looks back from byte i of the request.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int k = 0; k < MAX_PAT; k++) begin
        lane_win[i][k] = cat[HIST_DEPTH+i-k];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sss_lane u_lane (
      .win       (lane_win[g]),
      .tail_pat  (tail_pat),
      .tail_mask (tail_mask),
      .hit       (lane_hits[g])
    );
  end

  sss_merge u_merge (
    .lane_hits  (lane_hits),
    .cnt        (cnt),
    .bytes_seen (seen_eff),
    .pat_len    (pat_len_r),
    .can_match  (can_match),
    .match      (match)
  );

  // Advance the history by the number of bytes taken and saturate the count.
  always_comb begin
    logic [CAT_IDX_W-1:0] src;
    for (int h = 0; h < HIST_DEPTH; h++) begin
      src          = CAT_IDX_W'(HIST_DEPTH - 1 - h) + CAT_IDX_W'(cnt);
      hist_push[h] = cat[src];
    end
  end

  assign seen_sum = {1'b0, seen_eff} + (POS_BITS+1)'(cnt);
  assign seen_sat = (seen_sum >= PosMax) ? PosMax[POS_BITS-1:0] : seen_sum[POS_BITS-1:0];

  // A request yields a result on the first match or at the end of a stream
  // that found nothing; a finished search drops requests until a new stream.
  assign res_load = in_fire && !done_eff && (match.hit || in_req.last_of_stream);

  always_comb begin
    hist_nxt        = hist_r;
    bytes_seen_nxt  = bytes_seen_r;
    search_done_nxt = search_done_r;
    if (in_fire) begin
      hist_nxt        = done_eff ? hist_eff : hist_push;
      bytes_seen_nxt  = done_eff ? seen_eff : seen_sat;
      search_done_nxt = done_eff || match.hit || in_req.last_of_stream;
    end

    out_rsp_nxt.found          = match.hit;
    out_rsp_nxt.match_position = match.hit ? match.position : '0;

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r     <= '0;
      pat_word_r    <= '0;
      hist_r        <= '0;
      bytes_seen_r  <= '0;
      search_done_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      hist_r        <= hist_nxt;
      bytes_seen_r  <= bytes_seen_nxt;
      search_done_r <= search_done_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH: pat_len_r     <= cfg_data[LEN_W-1:0];
          REG_PATTERN_WORD0:  pat_word_r[0] <= cfg_data;
          REG_PATTERN_WORD1:  pat_word_r[1] <= cfg_data;
          REG_PATTERN_WORD2:  pat_word_r[2] <= cfg_data;
          REG_PATTERN_WORD3:  pat_word_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Hold the result payload until it is loaded again.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  `include "assert_macros.svh"

  `SSS_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, out_valid_r)
  `SSS_ASSERT_IMP(a_result_needs_open_search, clk, rst_n, res_load, !done_eff)
  `SSS_ASSERT_NXT(a_result_closes_search, clk, rst_n, res_load, search_done_r)
  `SSS_ASSERT_IMP(a_miss_has_zero_pos, clk, rst_n, out_valid_r && !out_rsp_r.found, out_rsp_r.match_position == '0)

endmodule
